// ----- rtl/pli_pkg.sv -----
package pli_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int INDEX_W         = 4;
    localparam int COUNT_W         = 5;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LAST,
        S_CHK_FIRST,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } pli_state_t;

    typedef struct packed {
        logic capture;
        logic res_rd;
        logic res_prev;
        logic save_prev;
        logic save_cur;
        logic mul_load;
        logic mul_step;
        logic div_step;
        logic finish;
    } pli_cmd_t;

    typedef struct packed {
        logic x_gt;
        logic x_lt;
        logic den_zero;
    } pli_stat_t;

endpackage

// ----- rtl/pli_ram.sv -----
module pli_ram import pli_pkg::*; #(
    parameter int WIDTH = 2 * DEF_VALUE_WIDTH,
    parameter int DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pli_ctrl.sv -----
module pli_ctrl import pli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           mode,
    input  logic                           cfg_valid,
    input  logic [COUNT_W-1:0]             points_used,
    input  pli_stat_t                      stat,
    output pli_cmd_t                       cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic                           busy,
    output logic                           done
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int MW = VALUE_WIDTH + 1;
    localparam int PW = 2 * MW;
    localparam int CW = $clog2(PW);

    pli_state_t          state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  points_used_reg;
    logic [IW-1:0]       last;

    // last used slot, with zero taken as one and saturation at the table size
    always_comb
    begin
        if (points_used_reg == '0)
        begin
            last = '0;
        end
        else if (32'(points_used_reg) > TABLE_DEPTH)
        begin
            last = IW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last = IW'(points_used_reg - COUNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            points_used_reg <= COUNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid)
            begin
                points_used_reg <= points_used;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        raddr      = last;
        case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (start && mode == MODE_QUERY)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST:
            begin
                raddr = last;
                if (stat.x_lt)
                begin
                    cmd.res_rd = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    state_next    = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                raddr    = IW'(1);
                idx_next = IW'(1);
                if (stat.x_gt || last == '0)
                begin
                    cmd.res_rd = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                raddr = idx_reg + IW'(1);
                if (stat.x_lt)
                begin
                    cmd.save_cur = 1'b1;
                    state_next   = S_PREP;
                end
                else if (idx_reg == last)
                begin
                    cmd.res_rd = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    idx_next      = idx_reg + IW'(1);
                end
            end
            S_PREP:
            begin
                if (stat.den_zero)
                begin
                    cmd.res_prev = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CW'(MW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(PW - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ----- rtl/pli_dp.sv -----
module pli_dp import pli_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  pli_cmd_t                      cmd,
    output pli_stat_t                     stat,
    input  logic signed [VALUE_WIDTH-1:0] x_value,
    input  logic [2*VALUE_WIDTH-1:0]      rd_data,
    output logic signed [VALUE_WIDTH-1:0] y_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int MW = VW + 1;
    localparam int PW = 2 * MW;

    localparam logic signed [MW+1:0] RES_MAX = {4'b0000, {(VW-1){1'b1}}};
    localparam logic signed [MW+1:0] RES_MIN = {4'b1111, {(VW-1){1'b0}}};

    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [VW-1:0] res_reg;
    logic [MW-1:0]        mcand_reg, mplier_reg, den_reg, rem_reg;
    logic [PW-1:0]        quo_reg;
    logic                 neg_reg;

    logic signed [VW-1:0] rd_x, rd_y;
    logic signed [MW-1:0] dx, dy, den;
    logic [MW-1:0]        dx_mag, dy_mag, den_mag;
    logic [PW-1:0]        mul_sum;
    logic [MW:0]          rem_sh;
    logic [MW+1:0]        rem_diff;
    logic [MW:0]          q_cap;
    logic signed [MW+1:0] y_ext, q_ext, r_sum;
    logic signed [VW-1:0] r_sat;

    assign rd_x = signed'(rd_data[2*VW-1:VW]);
    assign rd_y = signed'(rd_data[VW-1:0]);

    assign stat.x_gt     = (x_reg > rd_x);
    assign stat.x_lt     = (x_reg < rd_x);
    assign stat.den_zero = (den == '0);

    // segment differences, one bit wider than the values
    assign dx  = {x_reg[VW-1], x_reg} - {prev_x_reg[VW-1], prev_x_reg};
    assign dy  = {cur_y_reg[VW-1], cur_y_reg} - {prev_y_reg[VW-1], prev_y_reg};
    assign den = {cur_x_reg[VW-1], cur_x_reg} - {prev_x_reg[VW-1], prev_x_reg};

    assign dx_mag  = dx[MW-1]  ? (~dx + 1'b1)  : dx;
    assign dy_mag  = dy[MW-1]  ? (~dy + 1'b1)  : dy;
    assign den_mag = den[MW-1] ? (~den + 1'b1) : den;

    // shift-add multiply, msb of the multiplier first
    assign mul_sum = {quo_reg[PW-2:0], 1'b0}
                   + (mplier_reg[MW-1] ? {{MW{1'b0}}, mcand_reg} : {PW{1'b0}});

    // restoring divide, one quotient bit a cycle
    assign rem_sh   = {rem_reg, quo_reg[PW-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, den_reg};

    // any quotient beyond the value range saturates the same way
    assign q_cap = (quo_reg[PW-1:MW] != '0) ? {1'b1, {MW{1'b0}}}
                                            : {1'b0, quo_reg[MW-1:0]};
    assign y_ext = {{3{prev_y_reg[VW-1]}}, prev_y_reg};
    assign q_ext = signed'({1'b0, q_cap});
    assign r_sum = neg_reg ? (y_ext - q_ext) : (y_ext + q_ext);

    always_comb
    begin
        if (r_sum > RES_MAX)
        begin
            r_sat = {1'b0, {(VW-1){1'b1}}};
        end
        else if (r_sum < RES_MIN)
        begin
            r_sat = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            r_sat = r_sum[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= x_value;
        end
        if (cmd.save_prev)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.save_cur)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
        end
        if (cmd.mul_load)
        begin
            mcand_reg  <= dx_mag;
            mplier_reg <= dy_mag;
            den_reg    <= den_mag;
            neg_reg    <= dx[MW-1] ^ dy[MW-1] ^ den[MW-1];
            quo_reg    <= '0;
            rem_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            quo_reg    <= mul_sum;
            mplier_reg <= {mplier_reg[MW-2:0], 1'b0};
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[MW+1])
            begin
                rem_reg <= rem_diff[MW-1:0];
                quo_reg <= {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[MW-1:0];
                quo_reg <= {quo_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.res_rd)
        begin
            res_reg <= rd_y;
        end
        else if (cmd.res_prev)
        begin
            res_reg <= prev_y_reg;
        end
        else if (cmd.finish)
        begin
            res_reg <= r_sat;
        end
    end

    assign y_result = res_reg;

endmodule

// ----- rtl/piecewise_linear_interpolator_top.sv -----
// piecewise linear interpolator over a table of (x, y) breakpoints, signed Q16.16
//
// command channel: an item is taken when start is high and busy is low.
// mode low loads x_value/y_value into slot point_index (slots beyond the table
// are dropped); a load takes effect at once and gives no result, busy stays low.
// mode high queries y at x_value; busy rises until the result is out.
// result: y_result is valid for the single cycle in which done is high.
// the receiver cannot stall, so nothing holds the result back.
// config: points_used is written when cfg_valid is high; cfg_ready is always high.
// write it only while busy is low.
// query steps: a query returns a table y when x is below the first x, above the last
// used x, or clamped in the scan of k entries; an interpolated query scans k
// entries (one table read a cycle), then runs a one-bit-a-cycle multiply of
// VALUE_WIDTH+1 steps and a one-bit-a-cycle divide of 2*VALUE_WIDTH+2 steps.
// the next item is taken in the cycle after done.
// reset: control and points_used (to 1) clear; table contents are undefined
// until written.
module piecewise_linear_interpolator_top import pli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [INDEX_W-1:0]            point_index,
    input  logic signed [VALUE_WIDTH-1:0] x_value,
    input  logic signed [VALUE_WIDTH-1:0] y_value,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] y_result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [COUNT_W-1:0]            points_used
);

    localparam int IW = $clog2(TABLE_DEPTH);

    pli_cmd_t                 cmd;
    pli_stat_t                stat;
    logic [IW-1:0]            raddr;
    logic [2*VALUE_WIDTH-1:0] rd_data;
    logic                     we;

    assign cfg_ready = 1'b1;
    assign we = start && !busy && mode == MODE_LOAD && 32'(point_index) < TABLE_DEPTH;

    pli_ram #(
        .WIDTH (2 * VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (IW'(point_index)),
        .wdata ({x_value, y_value}),
        .raddr (raddr),
        .rdata (rd_data)
    );

    pli_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .cfg_valid   (cfg_valid),
        .points_used (points_used),
        .stat        (stat),
        .cmd         (cmd),
        .raddr       (raddr),
        .busy        (busy),
        .done        (done)
    );

    pli_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .x_value  (x_value),
        .rd_data  (rd_data),
        .y_result (y_result)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word outside a query");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("query did not end after its result word");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_QUERY) |=> busy)
        else $error("query word taken without going busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_LOAD) |=> !busy)
        else $error("load word made the block busy");

endmodule

// ----- sim/interp_check_pkg.sv -----
package interp_check_pkg;
    import pli_pkg::*;

    localparam int VW = DEF_VALUE_WIDTH;
    localparam int TD = DEF_TABLE_DEPTH;

    typedef longint unsigned u64_t;
    typedef logic signed [VW-1:0] value_t;

    localparam value_t V_MAX   = {1'b0, {(VW-1){1'b1}}};
    localparam value_t V_MIN   = {1'b1, {(VW-1){1'b0}}};
    localparam longint VAL_TOP = longint'(V_MAX);
    localparam longint VAL_BOT = longint'(V_MIN);
    localparam logic [127:0] QUOT_LIMIT = 128'd1 << 62;

    function automatic u64_t magnitude(longint v);
        return (v < 0) ? u64_t'(-v) : u64_t'(v);
    endfunction

    class interp_scoreboard;
        longint             bp_x[TD];
        longint             bp_y[TD];
        logic [COUNT_W-1:0] used_cnt;
        value_t             y_due[$];
        int                 errors;

        function new();
            foreach (bp_x[i])
            begin
                bp_x[i] = 0;
                bp_y[i] = 0;
            end
            used_cnt = COUNT_W'(1);
            errors   = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 100)
                $display("%0t mismatch: %s", $time, what);
        endtask

        function int unsigned live_points();
            int unsigned n;
            n = used_cnt;
            if (n == 0)
                n = 1;
            if (n > TD)
                n = TD;
            return n;
        endfunction

        function value_t interp_at(longint xq);
            int unsigned  n;
            int unsigned  i;
            longint       x0, y0, den, dy, dx, r;
            logic [127:0] prod, quot;
            u64_t         q;
            bit           neg;
            n = live_points();
            if (xq < bp_x[0])
                return value_t'(bp_y[0]);
            if (xq > bp_x[n-1])
                return value_t'(bp_y[n-1]);
            for (i = 1; i < n; i++)
            begin
                if (bp_x[i] > xq)
                begin
                    x0  = bp_x[i-1];
                    y0  = bp_y[i-1];
                    den = bp_x[i] - x0;
                    dy  = bp_y[i] - y0;
                    dx  = xq - x0;
                    if (den == 0)
                        return value_t'(y0);
                    neg  = ((dx < 0) != (dy < 0)) != (den < 0);
                    prod = 128'(magnitude(dx)) * 128'(magnitude(dy));
                    quot = prod / 128'(magnitude(den));
                    q    = (quot > QUOT_LIMIT) ? u64_t'(QUOT_LIMIT) : quot[63:0];
                    r    = neg ? y0 - longint'(q) : y0 + longint'(q);
                    if (r > VAL_TOP)
                        r = VAL_TOP;
                    if (r < VAL_BOT)
                        r = VAL_BOT;
                    return value_t'(r);
                end
            end
            return value_t'(bp_y[n-1]);
        endfunction

        function void note_word(logic m, logic [INDEX_W-1:0] idx, value_t xv, value_t yv);
            if (m == MODE_LOAD)
            begin
                bp_x[idx] = xv;
                bp_y[idx] = yv;
            end
            else
                y_due.push_back(interp_at(xv));
        endfunction

        task check_word(value_t got);
            value_t want;
            if (y_due.size() == 0)
                report_mismatch($sformatf("y_result %0d with no query outstanding", got));
            else
            begin
                want = y_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("y_result %0d, want %0d", got, want));
            end
        endtask
    endclass

endpackage

// ----- sim/tb_piecewise_linear_interpolator_top.sv -----
module tb_piecewise_linear_interpolator_top;
    import pli_pkg::*;
    import interp_check_pkg::*;

    localparam int ITEMS_TOTAL = 1900;
    localparam int QUIET_TAIL  = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 120;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               mode        = MODE_LOAD;
    logic [INDEX_W-1:0] point_index = '0;
    value_t             x_value     = '0;
    value_t             y_value     = '0;
    logic               cfg_valid   = 1'b0;
    logic [COUNT_W-1:0] points_used = '0;
    logic               busy;
    logic               done;
    logic               cfg_ready;
    value_t             y_result;

    interp_scoreboard sb = new();
    int               sent = 0;
    int               cycle_count = 0;
    bit               gaps_on = 1'b0;

    piecewise_linear_interpolator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .y_result    (y_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .points_used (points_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_word(y_result);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic value_t q16(int w);
        return value_t'(w) <<< 16;
    endfunction

    function automatic longint clip(longint v);
        if (v > VAL_TOP)
            return VAL_TOP;
        if (v < VAL_BOT)
            return VAL_BOT;
        return v;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_word(logic m, logic [INDEX_W-1:0] idx, value_t xv, value_t yv);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        start       = 1'b1;
        mode        = m;
        point_index = idx;
        x_value     = xv;
        y_value     = yv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(m, idx, xv, yv);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_points(logic [COUNT_W-1:0] v);
        start = 1'b0;
        @(posedge clk);
        while (busy || sb.y_due.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
        cfg_valid   = 1'b1;
        points_used = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.used_cnt = v;
        @(negedge clk);
        cfg_valid   = 1'b0;
        points_used = COUNT_W'($urandom);
    endtask

    function automatic value_t pick_query_x();
        int unsigned n;
        int unsigned i;
        int unsigned r;
        longint      lo, hi, xq;
        n = sb.live_points();
        r = $urandom_range(0, 19);
        if (r < 10 && n > 1)
        begin
            i  = $urandom_range(1, n - 1);
            lo = sb.bp_x[i-1];
            hi = sb.bp_x[i];
            if (hi > lo)
                xq = lo + longint'({$urandom, $urandom} % u64_t'(hi - lo));
            else
                xq = lo;
        end
        else if (r < 13)
            xq = sb.bp_x[$urandom_range(0, n - 1)];
        else if (r < 15)
            xq = $urandom_range(0, 1) ? VAL_BOT : VAL_TOP;
        else if (r < 17)
            xq = sb.bp_x[0] - $urandom_range(1, 1000);
        else if (r < 19)
            xq = sb.bp_x[n-1] + $urandom_range(0, 1000);
        else
            xq = longint'(value_t'($urandom));
        return value_t'(clip(xq));
    endfunction

    // ascending x with random spread, some repeated x, random y
    task automatic load_sorted(int unsigned cnt);
        longint xs[$];
        longint centre, width, v;
        value_t yv;
        int     j;
        width  = longint'(1) <<< $urandom_range(4, 33);
        centre = longint'(value_t'($urandom));
        for (j = 0; j < cnt; j++)
        begin
            v = clip(centre - width / 2 + longint'({$urandom, $urandom} % u64_t'(width)));
            if (j > 0 && $urandom_range(0, 9) == 0)
                v = xs[j-1];
            xs.push_back(v);
        end
        xs.sort();
        for (j = 0; j < cnt; j++)
        begin
            yv = $urandom;
            if ($urandom_range(0, 1))
                yv = yv >>> $urandom_range(0, 31);
            send_word(MODE_LOAD, INDEX_W'(j), value_t'(xs[j]), yv);
        end
    endtask

    task automatic run_directed();
        write_points(5'd1);
        send_word(MODE_LOAD,  4'd0,  q16(1), q16(2));
        send_word(MODE_QUERY, 4'hf,  V_MIN,  V_MAX);
        send_word(MODE_QUERY, 4'h0,  q16(1), '0);
        send_word(MODE_QUERY, 4'h5,  V_MAX,  '0);
        // zero points behaves as one
        write_points(5'd0);
        send_word(MODE_QUERY, 4'h0,  '0,     V_MIN);
        send_word(MODE_LOAD,  4'd0,  q16(-2), q16(-4));
        send_word(MODE_LOAD,  4'd1,  '0,      q16(1));
        send_word(MODE_LOAD,  4'd2,  '0,      q16(7));
        send_word(MODE_LOAD,  4'd3,  q16(3),  q16(10));
        write_points(5'd4);
        send_word(MODE_QUERY, 4'h3,  q16(-3), '0);
        send_word(MODE_QUERY, 4'h9,  q16(-2), '1);
        send_word(MODE_QUERY, 4'h0,  q16(-1), '0);
        send_word(MODE_QUERY, 4'ha,  '0,      '1);
        send_word(MODE_QUERY, 4'h0,  32'sh0002_8000, '0);
        send_word(MODE_QUERY, 4'hc,  q16(3),  '0);
        send_word(MODE_QUERY, 4'h0,  V_MAX,   '0);
        // widest possible segment
        send_word(MODE_LOAD,  4'd0,  V_MIN,   V_MAX);
        send_word(MODE_LOAD,  4'd1,  V_MAX,   V_MIN);
        send_word(MODE_LOAD,  4'd15, V_MAX,   V_MIN);
        write_points(5'd2);
        send_word(MODE_QUERY, 4'h0,  '0,      '0);
        send_word(MODE_QUERY, 4'h7,  V_MAX - 1, '0);
        send_word(MODE_QUERY, 4'hf,  V_MIN,   '0);
    endtask

    initial
    begin
        logic [COUNT_W-1:0] n_cfg;
        bit                 first;
        first = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        while (sent < ITEMS_TOTAL)
        begin
            gaps_on = (sent < ITEMS_TOTAL - QUIET_TAIL) && $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 9))
                0:       n_cfg = '0;
                1:       n_cfg = COUNT_W'(1);
                2:       n_cfg = COUNT_W'(TD);
                3:       n_cfg = '1;
                4:       n_cfg = COUNT_W'($urandom_range(TD + 1, 31));
                default: n_cfg = COUNT_W'($urandom_range(2, TD));
            endcase
            write_points(n_cfg);
            if (first || $urandom_range(0, 3) != 0)
            begin
                load_sorted(first ? TD : sb.live_points());
                first = 1'b0;
                repeat ($urandom_range(10, 50))
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(MODE_LOAD, INDEX_W'($urandom), value_t'($urandom),
                                  value_t'($urandom));
                    else
                        send_word(MODE_QUERY, INDEX_W'($urandom), pick_query_x(),
                                  value_t'($urandom));
                end
            end
            else
            begin
                // unsorted table and arbitrary queries
                repeat ($urandom_range(10, 40))
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_word(MODE_LOAD, INDEX_W'($urandom), value_t'($urandom),
                                  value_t'($urandom));
                    else
                        send_word(MODE_QUERY, INDEX_W'($urandom),
                                  $urandom_range(0, 1) ? pick_query_x() : value_t'($urandom),
                                  value_t'($urandom));
                end
            end
        end
        start = 1'b0;
        @(posedge clk);
        while (sb.y_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
